/* hw/rtl/sbus_pkg.sv */
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared types and constants for the serial-bus frame receiver.
// ----------------------------------------------------------------------------
package sbus_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int POS_W       = 5;
  localparam int CH_BITS     = 11;
  localparam int CH_IDX_W    = 5;
  localparam int CNT_W       = 5;
  // worst case: 10 leftover bits plus one fresh byte
  localparam int ACC_W       = 18;

  localparam logic [7:0]          SYNC_BYTE    = 8'h0F;
  localparam logic [POS_W-1:0]    FIRST_DATA   = 5'd1;
  localparam logic [POS_W-1:0]    FLAGS_POS    = 5'd23;
  localparam logic [POS_W-1:0]    LAST_POS     = 5'd24;
  localparam logic [POS_W-1:0]    FRAME_LEN    = 5'd25;
  localparam logic [CH_BITS-1:0]  DIGITAL_LOW  = 11'd173;
  localparam logic [CH_BITS-1:0]  DIGITAL_HIGH = 11'd1812;
  localparam logic [CH_IDX_W-1:0] LAST_ANALOG  = 5'd15;
  localparam logic [CH_IDX_W-1:0] CH_DIG0      = 5'd16;
  localparam logic [CH_IDX_W-1:0] CH_DIG1      = 5'd17;
  localparam logic [CNT_W-1:0]    CH_BITS_CNT  = 5'd11;
  localparam logic [CNT_W-1:0]    BYTE_BITS    = 5'd8;
  localparam logic [15:0]         GAP_RESET    = 16'd3500;

  // bit positions within the flags byte
  localparam int FLAG_CH16     = 0;
  localparam int FLAG_CH17     = 1;
  localparam int FLAG_LOST     = 2;
  localparam int FLAG_FAILSAFE = 3;

  typedef enum logic [1:0] {
    STATUS_COMPLETE = 2'd0,
    STATUS_FAILSAFE = 2'd1,
    STATUS_DROPPED  = 2'd2
  } status_t;

  typedef logic [POS_W-1:0] addr_t;

  // decode request from the byte intake to the unpacker
  typedef struct packed {
    logic       start;
    logic [7:0] flags;
  } decode_req_t;

endpackage

/* hw/rtl/sbus_frame_mem.sv */
// ----------------------------------------------------------------------------
// sbus_frame_mem
// Frame byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbus_frame_mem (
  input  logic                clk,
  input  logic                wr_en,
  input  sbus_pkg::addr_t     wr_addr,
  input  logic [7:0]          wr_data,
  input  sbus_pkg::addr_t     rd_addr,
  output logic [7:0]          rd_data
);

  logic [7:0] mem_r [sbus_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* hw/rtl/sbus_unpack.sv */
// ----------------------------------------------------------------------------
// sbus_unpack
// Channel unpacker: pulls frame bytes one at a time into a bit accumulator
// and shifts out 11-bit channels, then the two digital channels.
// ----------------------------------------------------------------------------
module sbus_unpack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sbus_pkg::decode_req_t     req,
  output logic                      idle,
  output sbus_pkg::addr_t           rd_addr,
  input  logic [7:0]                rd_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,
  output logic                      out_tlast
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_ACC  = 5'b00100,
    S_EMIT = 5'b01000,
    S_DIG  = 5'b10000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [sbus_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [sbus_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [sbus_pkg::CH_IDX_W-1:0]    ch_r, ch_nxt;
  sbus_pkg::addr_t                  idx_r, idx_nxt;
  logic [7:0]                       flags_r, flags_nxt;
  sbus_pkg::status_t                status_r, status_nxt;
  logic [sbus_pkg::CNT_W-1:0]       cnt_left;
  logic [sbus_pkg::CH_BITS-1:0]     value;
  logic                             dig_bit;

  assign cnt_left = cnt_r - sbus_pkg::CH_BITS_CNT;
  assign dig_bit  = (ch_r == sbus_pkg::CH_DIG0) ? flags_r[sbus_pkg::FLAG_CH16]
                                                : flags_r[sbus_pkg::FLAG_CH17];

  always_comb begin
    value = acc_r[sbus_pkg::CH_BITS-1:0];
    if (state_r == S_DIG) begin
      value = dig_bit ? sbus_pkg::DIGITAL_HIGH : sbus_pkg::DIGITAL_LOW;
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign rd_addr    = idx_r;
  assign out_tvalid = (state_r == S_EMIT) || (state_r == S_DIG);
  assign out_tlast  = (state_r == S_DIG) && (ch_r == sbus_pkg::CH_DIG1);
  assign out_tdata  = {6'd0, status_r, value, ch_r};

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    ch_nxt     = ch_r;
    idx_nxt    = idx_r;
    flags_nxt  = flags_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt = S_RD;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          ch_nxt    = '0;
          idx_nxt   = sbus_pkg::FIRST_DATA;
          flags_nxt = req.flags;
          priority if (req.flags[sbus_pkg::FLAG_FAILSAFE]) begin
            status_nxt = sbus_pkg::STATUS_FAILSAFE;
          end else if (req.flags[sbus_pkg::FLAG_LOST]) begin
            status_nxt = sbus_pkg::STATUS_DROPPED;
          end else begin
            status_nxt = sbus_pkg::STATUS_COMPLETE;
          end
        end
      end
      S_RD: begin
        // read address presented this cycle, data lands next cycle
        idx_nxt   = idx_r + 5'd1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r | ({10'd0, rd_data} << cnt_r);
        cnt_nxt = cnt_r + sbus_pkg::BYTE_BITS;
        state_nxt = (cnt_nxt >= sbus_pkg::CH_BITS_CNT) ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (out_tready) begin
          acc_nxt = acc_r >> sbus_pkg::CH_BITS;
          cnt_nxt = cnt_left;
          ch_nxt  = ch_r + 5'd1;
          priority if (ch_r == sbus_pkg::LAST_ANALOG) begin
            state_nxt = S_DIG;
          end else if (cnt_left >= sbus_pkg::CH_BITS_CNT) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_DIG: begin
        if (out_tready) begin
          ch_nxt = ch_r + 5'd1;
          if (ch_r == sbus_pkg::CH_DIG1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
    ch_r     <= ch_nxt;
    idx_r    <= idx_nxt;
    flags_r  <= flags_nxt;
    status_r <= status_nxt;
  end

endmodule

/* hw/rtl/sbus_frame_receiver.sv */
// A byte that does not complete a frame leaves the decoder idle, so bytes
// can be taken back to back. The 25th byte starts a decode that reads the
// buffered channel bytes through read and accumulate states, then emits 18
// results, stretched by output back-pressure; in_tready is low meanwhile.
// Reset (rst_n low, synchronous): position and start time to 0, gap to
// 3500 us, decoder idle; the frame buffer itself is not cleared.
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Serial-bus frame receiver with 16 analogue and 2 digital channel decoder.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [7:0] rx_byte, [39:8] now_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [4:0] channel_index, [15:5] channel_value,
                                   // [17:16] frame_status, [23:18] zero
  output logic        out_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data     // frame_gap_us
);

  logic [15:0]           gap_r;
  sbus_pkg::addr_t       pos_r, pos_nxt;
  logic [31:0]           start_r, start_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic                  in_xact;
  logic [7:0]            rx_byte;
  logic [31:0]           now_us;
  logic [31:0]           diff;
  logic                  gap_hit;
  sbus_pkg::addr_t       pos_eff;
  logic                  wr_en;
  sbus_pkg::decode_req_t req;
  logic                  dec_idle;
  sbus_pkg::addr_t       rd_addr;
  logic [7:0]            rd_data;

  assign rx_byte   = in_tdata[7:0];
  assign now_us    = in_tdata[39:8];
  assign in_tready = dec_idle;
  assign in_xact   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // a wrapped (negative) difference never counts as a gap
  assign diff    = now_us - start_r;
  assign gap_hit = !diff[31] && (diff > {16'd0, gap_r});
  assign pos_eff = gap_hit ? '0 : pos_r;

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    flags_nxt = flags_r;
    wr_en     = 1'b0;
    req       = '{start: 1'b0, flags: flags_r};
    if (in_xact) begin
      pos_nxt = pos_eff;
      priority if (pos_eff == '0 && rx_byte != sbus_pkg::SYNC_BYTE) begin
        pos_nxt = '0;
      end else if (pos_eff < sbus_pkg::FRAME_LEN) begin
        wr_en   = 1'b1;
        pos_nxt = pos_eff + 5'd1;
        if (pos_eff == '0) begin
          start_nxt = now_us;
        end
        if (pos_eff == sbus_pkg::FLAGS_POS) begin
          flags_nxt = rx_byte;
        end
        if (pos_eff == sbus_pkg::LAST_POS) begin
          req.start = 1'b1;
        end
      end else begin
        pos_nxt = pos_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= sbus_pkg::GAP_RESET;
      pos_r   <= '0;
      start_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_data;
      end
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

  sbus_frame_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_eff),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbus_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .idle       (dec_idle),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // decoder output and byte intake never run together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while results pending");

  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[4:0] == sbus_pkg::CH_DIG1))
    else $error("tlast on wrong channel");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'd3))
    else $error("illegal frame status");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("decoder not idle after last result");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (pos_r == sbus_pkg::FRAME_LEN) && !in_tready)
    else $error("decode start without full frame");

endmodule
